[rtl/core/stepper_phase_sequencer_top_defines.svh]
// Assertion macros for the stepper phase sequencer.
`ifndef STEPPER_PHASE_SEQUENCER_TOP_DEFINES_SVH
`define STEPPER_PHASE_SEQUENCER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on clk, off while rst_n is low.
`define STEPSEQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Antecedent in one cycle, consequent in the next.
`define STEPSEQ_ASSERT_NEXT(label, ante, cons, msg) \
    `STEPSEQ_ASSERT(label, (ante) |=> (cons), msg)
`else
`define STEPSEQ_ASSERT(label, prop, msg)
`define STEPSEQ_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

[rtl/core/stepseq_pkg.sv]
// Shared types, constants and coil tables for the stepper phase sequencer.
package stepseq_pkg;

    localparam int POSITION_WIDTH_DEF = 32;
    localparam int PERIOD_WIDTH_DEF   = 16;
    localparam int TARGET_WIDTH       = 32;
    localparam int CFG_DATA_WIDTH     = 16;
    localparam int CFG_INDEX_WIDTH    = 3;
    localparam int COIL_WIDTH         = 4;
    localparam int PHASE_WIDTH        = 3;
    // wide enough for target minus position plus one revolution
    localparam int CALC_W             = 34;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_DRIVE_MODE      = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STEPS_PER_REV   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STEP_PERIOD     = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SHORTEST_PATH   = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HOLD_AFTER_MOVE = 3'd4;

    localparam logic [1:0] MODE_TWO_WIRE = 2'd0;
    localparam logic [1:0] MODE_FULL     = 2'd1;
    localparam logic [1:0] MODE_HALF     = 2'd2;

    localparam logic [1:0]  DRIVE_MODE_RST    = MODE_FULL;
    localparam logic [15:0] STEPS_PER_REV_RST = 16'd4076;
    localparam logic [15:0] STEP_PERIOD_RST   = 16'd500;

    typedef struct packed {
        logic [1:0]  drive_mode;
        logic [15:0] steps_per_rev;
        logic [15:0] step_period;
        logic        shortest_path;
        logic        hold_after_move;
    } cfg_t;

    // Coil pattern for a phase already reduced to the mode's phase count.
    function automatic logic [COIL_WIDTH-1:0] coil_pattern(
        input logic [1:0]             mode,
        input logic [PHASE_WIDTH-1:0] ph
    );
        logic [COIL_WIDTH-1:0] pat;
        if (mode == MODE_TWO_WIRE)
        begin
            case (ph[1:0])
                2'd0:    pat = 4'h4;
                2'd1:    pat = 4'hC;
                2'd2:    pat = 4'h8;
                default: pat = 4'h0;
            endcase
        end
        else if (mode == MODE_HALF)
        begin
            case (ph)
                3'd0:    pat = 4'h8;
                3'd1:    pat = 4'hC;
                3'd2:    pat = 4'h4;
                3'd3:    pat = 4'h6;
                3'd4:    pat = 4'h2;
                3'd5:    pat = 4'h3;
                3'd6:    pat = 4'h1;
                default: pat = 4'h9;
            endcase
        end
        else
        begin
            case (ph[1:0])
                2'd0:    pat = 4'hC;
                2'd1:    pat = 4'h6;
                2'd2:    pat = 4'h3;
                default: pat = 4'h9;
            endcase
        end
        return pat;
    endfunction

endpackage

[rtl/core/stepseq_cfg_regs.sv]
// Configuration register file of the stepper phase sequencer.
module stepseq_cfg_regs (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [stepseq_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [stepseq_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output stepseq_pkg::cfg_t                     cfg
);
    import stepseq_pkg::*;

    cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_DRIVE_MODE:      cfg_next.drive_mode      = cfg_data[1:0];
                CFG_STEPS_PER_REV:   cfg_next.steps_per_rev   = cfg_data[15:0];
                CFG_STEP_PERIOD:     cfg_next.step_period     = cfg_data[15:0];
                CFG_SHORTEST_PATH:   cfg_next.shortest_path   = cfg_data[0];
                CFG_HOLD_AFTER_MOVE: cfg_next.hold_after_move = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_mode      <= DRIVE_MODE_RST;
            cfg_reg.steps_per_rev   <= STEPS_PER_REV_RST;
            cfg_reg.step_period     <= STEP_PERIOD_RST;
            cfg_reg.shortest_path   <= 1'b0;
            cfg_reg.hold_after_move <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/stepseq_in_stage.sv]
// Input register stage: captures one request per transfer.
module stepseq_in_stage (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  req_type,
    input  logic [stepseq_pkg::TARGET_WIDTH-1:0]  target_position,
    input  logic                                  advance,
    output logic                                  s1_valid,
    output logic                                  s1_req,
    output logic [stepseq_pkg::TARGET_WIDTH-1:0]  s1_tgt
);
    import stepseq_pkg::*;

    logic                    valid_reg, valid_next;
    logic                    req_reg;
    logic [TARGET_WIDTH-1:0] tgt_reg;
    logic                    take;

    // held item leaves on advance, so a new one can land in the same cycle
    assign in_stall = valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_reg <= req_type;
            tgt_reg <= target_position;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_req   = req_reg;
    assign s1_tgt   = tgt_reg;

endmodule

[rtl/core/stepseq_core.sv]
// Sequencer state and combinational step decision.
`include "stepper_phase_sequencer_top_defines.svh"

module stepseq_core #(
    parameter int POSITION_WIDTH = stepseq_pkg::POSITION_WIDTH_DEF,
    parameter int PERIOD_WIDTH   = stepseq_pkg::PERIOD_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  stepseq_pkg::cfg_t                    cfg,
    input  logic                                 advance,
    input  logic                                 s1_req,
    input  logic [stepseq_pkg::TARGET_WIDTH-1:0] s1_tgt,
    output logic [stepseq_pkg::COIL_WIDTH-1:0]   res_coils,
    output logic [POSITION_WIDTH-1:0]            res_position,
    output logic                                 res_direction,
    output logic                                 res_moving
);
    import stepseq_pkg::*;

    localparam longint POS_MAX_L = (longint'(1) <<< (POSITION_WIDTH - 1)) - 1;
    localparam logic signed [CALC_W-1:0] POS_MAX = CALC_W'(POS_MAX_L);
    localparam logic signed [CALC_W-1:0] POS_MIN = CALC_W'(-POS_MAX_L - 1);
    localparam logic signed [CALC_W-1:0] ONE_W   = CALC_W'(1);

    logic signed [POSITION_WIDTH-1:0] pos_reg, pos_next;
    logic [PHASE_WIDTH-1:0]           phase_reg, phase_next;
    logic [PERIOD_WIDTH-1:0]          wait_reg, wait_next;
    logic                             energized_reg, energized_next;
    logic                             hold_done_reg, hold_done_next;
    logic                             dir_reg, dir_next;

    logic [15:0]              rev_u;
    logic [15:0]              load16;
    logic [PERIOD_WIDTH-1:0]  period_load;
    logic signed [CALC_W-1:0] pos_w, tgt_w, tgt_sat, rev_w, half_w, neg_half_w, half_m1_neg;
    logic signed [CALC_W-1:0] delta, rev_minus_d, rev_plus_d, pos_step, pos_wrap;
    logic                     sp_fwd, sp_back, dr_fwd, dr_back, go_fwd, go_back, do_step;
    logic                     half_mode;
    logic [PHASE_WIDTH-1:0]   last_ph, coil_ph;

    // revolution below two counts as two
    assign rev_u       = (cfg.steps_per_rev < 16'd2) ? 16'd2 : cfg.steps_per_rev;
    assign rev_w       = signed'(CALC_W'(rev_u));
    assign half_w      = signed'(CALC_W'(rev_u[15:1]));
    assign neg_half_w  = -half_w;
    assign half_m1_neg = ONE_W - half_w;

    assign load16      = (cfg.step_period == 16'd0) ? 16'd0 : cfg.step_period - 16'd1;
    assign period_load = PERIOD_WIDTH'(load16);

    assign pos_w = CALC_W'(pos_reg);
    assign tgt_w = CALC_W'(signed'(s1_tgt));

    // direct mode: saturate target into the position range
    always_comb
    begin
        if (tgt_w > POS_MAX)
            tgt_sat = POS_MAX;
        else if (tgt_w < POS_MIN)
            tgt_sat = POS_MIN;
        else
            tgt_sat = tgt_w;
    end
    assign dr_fwd  = tgt_sat > pos_w;
    assign dr_back = tgt_sat < pos_w;

    // shortest path: fold distances longer than half a turn
    assign delta       = tgt_w - pos_w;
    assign rev_minus_d = rev_w - delta;
    assign rev_plus_d  = rev_w + delta;

    always_comb
    begin
        if (!delta[CALC_W-1])
        begin
            if (delta > half_w)
            begin
                sp_fwd  = rev_minus_d[CALC_W-1];
                sp_back = !rev_minus_d[CALC_W-1] && (rev_minus_d != '0);
            end
            else
            begin
                sp_fwd  = delta != '0;
                sp_back = 1'b0;
            end
        end
        else
        begin
            if (delta < neg_half_w)
            begin
                sp_fwd  = !rev_plus_d[CALC_W-1] && (rev_plus_d != '0);
                sp_back = rev_plus_d[CALC_W-1];
            end
            else
            begin
                sp_fwd  = 1'b0;
                sp_back = 1'b1;
            end
        end
    end

    assign go_fwd  = cfg.shortest_path ? sp_fwd  : dr_fwd;
    assign go_back = cfg.shortest_path ? sp_back : dr_back;
    assign do_step = go_fwd || go_back;

    assign pos_step = go_fwd ? pos_w + ONE_W : pos_w - ONE_W;

    always_comb
    begin
        if (pos_step > half_w)
            pos_wrap = half_m1_neg;
        else if (pos_step < half_m1_neg)
            pos_wrap = half_w;
        else
            pos_wrap = pos_step;
    end

    assign half_mode = cfg.drive_mode == MODE_HALF;
    assign last_ph   = half_mode ? 3'd7 : 3'd3;

    always_comb
    begin
        pos_next       = pos_reg;
        phase_next     = phase_reg;
        wait_next      = wait_reg;
        energized_next = energized_reg;
        hold_done_next = hold_done_reg;
        dir_next       = dir_reg;
        if (advance)
        begin
            if (s1_req)
            begin
                pos_next = '0;
            end
            else if (wait_reg != '0)
            begin
                wait_next = wait_reg - 1'b1;
            end
            else if (do_step)
            begin
                dir_next = go_back;
                pos_next = cfg.shortest_path ? POSITION_WIDTH'(pos_wrap)
                                             : POSITION_WIDTH'(pos_step);
                if (go_fwd)
                    phase_next = (phase_reg >= last_ph) ? '0 : phase_reg + 1'b1;
                else if (phase_reg == '0 || (!half_mode && phase_reg > 3'd4))
                    phase_next = last_ph;
                else
                    phase_next = phase_reg - 1'b1;
                energized_next = 1'b1;
                hold_done_next = 1'b0;
                wait_next      = period_load;
            end
            else if (energized_reg)
            begin
                if (cfg.hold_after_move && !hold_done_reg)
                begin
                    hold_done_next = 1'b1;
                    wait_next      = period_load;
                end
                else
                begin
                    energized_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            phase_reg     <= '0;
            wait_reg      <= '0;
            energized_reg <= 1'b0;
            hold_done_reg <= 1'b0;
            dir_reg       <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            wait_reg      <= wait_next;
            energized_reg <= energized_next;
            hold_done_reg <= hold_done_next;
            dir_reg       <= dir_next;
        end
    end

    // stale phase from another mode is reduced modulo the phase count
    assign coil_ph       = half_mode ? phase_next : {1'b0, phase_next[1:0]};
    assign res_coils     = energized_next ? coil_pattern(cfg.drive_mode, coil_ph) : '0;
    assign res_position  = pos_next;
    assign res_direction = dir_next;
    assign res_moving    = energized_next;

    `STEPSEQ_ASSERT_NEXT(a_home_zero, advance && s1_req, pos_reg == '0, "set home did not clear position")
    `STEPSEQ_ASSERT_NEXT(a_wait_holds_pos, advance && !s1_req && wait_reg != '0, pos_reg == $past(pos_reg) && phase_reg == $past(phase_reg), "position moved during wait")
    `STEPSEQ_ASSERT_NEXT(a_step_reload, advance && !s1_req && wait_reg == '0 && do_step, energized_reg && wait_reg == $past(period_load), "step did not reload the period counter")
    `STEPSEQ_ASSERT(a_idle_no_wait, !energized_reg |-> wait_reg == '0, "period counter running with coils off")

endmodule

[rtl/core/stepseq_out_stage.sv]
// Result register stage: holds one result until the receiver takes it.
module stepseq_out_stage #(
    parameter int POSITION_WIDTH = stepseq_pkg::POSITION_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               load,
    input  logic [stepseq_pkg::COIL_WIDTH-1:0] res_coils,
    input  logic [POSITION_WIDTH-1:0]          res_position,
    input  logic                               res_direction,
    input  logic                               res_moving,
    output logic                               space,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [stepseq_pkg::COIL_WIDTH-1:0] coils,
    output logic [POSITION_WIDTH-1:0]          position,
    output logic                               direction,
    output logic                               moving
);
    import stepseq_pkg::*;

    logic                      valid_reg, valid_next;
    logic [COIL_WIDTH-1:0]     coils_reg;
    logic [POSITION_WIDTH-1:0] position_reg;
    logic                      direction_reg;
    logic                      moving_reg;

    assign space = !valid_reg || !out_stall;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            coils_reg     <= res_coils;
            position_reg  <= res_position;
            direction_reg <= res_direction;
            moving_reg    <= res_moving;
        end
    end

    assign out_valid = valid_reg;
    assign coils     = coils_reg;
    assign position  = position_reg;
    assign direction = direction_reg;
    assign moving    = moving_reg;

endmodule

[rtl/core/stepper_phase_sequencer_top.sv]
// Top level of the unipolar stepper phase sequencer.
//
// Usage:
//  - Input channel (in_valid / in_stall): one transfer per timebase tick or
//    set-home request (req_type 1), with the target step position.
//  - Output channel (out_valid / out_stall): exactly one result per input
//    transfer: coil bits, current position, last direction, moving flag.
//  - Config port: cfg_wr_en writes cfg_data to register cfg_index
//    (0 drive_mode, 1 steps_per_rev, 2 step_period, 3 shortest_path,
//    4 hold_after_move). Write only while no transfer is in flight.
//  - Path: a transfer is captured in the input register, then the step
//    logic feeds the result register, where out_valid rises; while the result
//    register is full, the request waits in the input register.
//  - Throughput: one item per clock while out_stall is low; the whole step
//    decision, position update and coil lookup lie between the input and result registers.
//  - Stall: when out_stall holds a result, one more item is still taken into
//    the input register; after that in_stall rises until the result leaves.
//  - Reset (rst_n low, async): position, phase, period counter and energized
//    state clear, both channels empty, registers return to their defaults
//    (full step, 4076 steps/rev, period 500, direct path, no hold).
module stepper_phase_sequencer_top #(
    parameter int POSITION_WIDTH = stepseq_pkg::POSITION_WIDTH_DEF,
    parameter int PERIOD_WIDTH   = stepseq_pkg::PERIOD_WIDTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // configuration
    input  logic                                    cfg_wr_en,
    input  logic [stepseq_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [stepseq_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    // input channel
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic                                    req_type,
    input  logic [stepseq_pkg::TARGET_WIDTH-1:0]    target_position,
    // output channel
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [stepseq_pkg::COIL_WIDTH-1:0]      coils,
    output logic [POSITION_WIDTH-1:0]               position,
    output logic                                    direction,
    output logic                                    moving
);
    import stepseq_pkg::*;

    cfg_t                      cfg;
    logic                      s1_valid;
    logic                      s1_req;
    logic [TARGET_WIDTH-1:0]   s1_tgt;
    logic                      out_space;
    logic                      advance;
    logic [COIL_WIDTH-1:0]     res_coils;
    logic [POSITION_WIDTH-1:0] res_position;
    logic                      res_direction;
    logic                      res_moving;

    // the held request is processed when the result register can take it
    assign advance = s1_valid && out_space;

    stepseq_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    stepseq_in_stage u_in (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .target_position (target_position),
        .advance         (advance),
        .s1_valid        (s1_valid),
        .s1_req          (s1_req),
        .s1_tgt          (s1_tgt)
    );

    stepseq_core #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .PERIOD_WIDTH   (PERIOD_WIDTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .advance       (advance),
        .s1_req        (s1_req),
        .s1_tgt        (s1_tgt),
        .res_coils     (res_coils),
        .res_position  (res_position),
        .res_direction (res_direction),
        .res_moving    (res_moving)
    );

    stepseq_out_stage #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .res_coils     (res_coils),
        .res_position  (res_position),
        .res_direction (res_direction),
        .res_moving    (res_moving),
        .space         (out_space),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .coils         (coils),
        .position      (position),
        .direction     (direction),
        .moving        (moving)
    );

endmodule
